>>> hdl/byte_fifo_with_line_detect_defines.svh
// Assertion macros for the byte FIFO with line detect.
// Used by byte_fifo_with_line_detect.sv; relies on clk and rst in scope.
`ifndef BYTE_FIFO_WITH_LINE_DETECT_DEFINES_SVH
`define BYTE_FIFO_WITH_LINE_DETECT_DEFINES_SVH
`ifndef SYNTHESIS
`define BFLD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BFLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BFLD_ASSERT_SAME(label, ante, cons)
`define BFLD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/bfld_pkg.sv
// Shared types and constants for the byte FIFO with line detect.
// No dependencies.
`timescale 1ns / 1ps

package bfld_pkg;

  localparam int CNT_W = 9;
  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_COMPLETE   = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             read_valid;
    logic             write_accepted;
    logic [1:0]       line_status;
    logic [CNT_W-1:0] line_length;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } rsp_t;

endpackage

>>> hdl/bfld_seq.sv
// Sequencer for the byte FIFO: byte memory, pointers and the line scanner.
// An index incrementer and a newline compare step through the
// stored bytes one per cycle. Depends on bfld_pkg.
`timescale 1ns / 1ps

module bfld_seq #(
  parameter int DEPTH = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bfld_pkg::req_t req,
  output logic          done_valid,
  input  logic          done_ready,
  output bfld_pkg::rsp_t done
);

  localparam int PW = $clog2(DEPTH);
  localparam int WW = (PW + 1 > bfld_pkg::CNT_W) ? PW + 1 : bfld_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN, S_DONE} state_t;

  state_t state;
  logic [PW-1:0] rp, wp, idx, cnt;
  logic first;
  bfld_pkg::rsp_t res;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic [PW-1:0] raddr;
  logic mem_we;

  logic [PW-1:0] used, idx_inc;
  logic full, empty, is_nl;
  logic [PW:0] len_full;
  logic [WW-1:0] len_wide, used_wide, free_wide;

  always_comb begin
    used      = wp - rp;
    full      = (used == PW'(DEPTH - 1));
    empty     = (used == '0);
    idx_inc   = idx + 1'b1;
    is_nl     = (mem_q == bfld_pkg::NEWLINE);
    raddr     = (state == S_SCAN) ? idx_inc : rp;
    mem_we    = (state == S_IDLE) && req_valid && (req.operation == bfld_pkg::OP_PUSH) && !full;
    len_full  = {1'b0, cnt} + 1'b1;
    len_wide  = WW'(len_full);
    used_wide = WW'(used);
    free_wide = WW'(~used);
    req_ready = (state == S_IDLE);
    done_valid = (state == S_DONE);
    done      = res;
    done.used_count = used_wide[bfld_pkg::CNT_W-1:0];
    done.free_count = free_wide[bfld_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= req.data_byte;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rp    <= '0;
      wp    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            idx   <= rp;
            cnt   <= '0;
            first <= 1'b1;
            unique case (req.operation)
              bfld_pkg::OP_PUSH: begin
                res <= '{write_accepted: !full, default: '0};
                if (!full) begin
                  wp <= wp + 1'b1;
                end
                state <= S_DONE;
              end
              bfld_pkg::OP_POP: begin
                res   <= '0;
                state <= empty ? S_DONE : S_POP;
              end
              bfld_pkg::OP_QUERY: begin
                res   <= '0;
                state <= empty ? S_DONE : S_SCAN;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_POP: begin
          res.read_data  <= mem_q;
          res.read_valid <= 1'b1;
          rp    <= rp + 1'b1;
          state <= S_DONE;
        end
        S_SCAN: begin
          first <= 1'b0;
          if (first && is_nl) begin
            // skip one leading newline
            idx <= idx_inc;
            if (idx_inc == wp) begin
              res.line_status <= bfld_pkg::ST_NONE;
              state <= S_DONE;
            end
          end else if (is_nl) begin
            if (cnt == '0) begin
              res.line_status <= bfld_pkg::ST_NONE;
            end else begin
              res.line_status <= bfld_pkg::ST_COMPLETE;
              res.line_length <= len_wide[bfld_pkg::CNT_W-1:0];
            end
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            idx <= idx_inc;
            if (idx_inc == wp) begin
              res.line_status <= bfld_pkg::ST_INCOMPLETE;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/byte_fifo_with_line_detect.sv
// Byte FIFO with line detect: top level with the output word register.
// Path to result register: push via S_DONE, pop via S_POP and S_DONE, query
// via S_SCAN (one stored byte per cycle through the scan loop) and S_DONE. One
// word in flight: the next word waits till the last leaves S_DONE; rsp can stall.
// Reset (rst, synchronous) clears pointers and control; memory is not cleared.
// Depends on bfld_pkg, bfld_seq and byte_fifo_with_line_detect_defines.svh.
`timescale 1ns / 1ps
`include "byte_fifo_with_line_detect_defines.svh"

module byte_fifo_with_line_detect #(
  parameter int DEPTH = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bfld_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bfld_pkg::rsp_t rsp
);

  logic done_valid, done_ready;
  bfld_pkg::rsp_t done;

  bfld_seq #(.DEPTH(DEPTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done)
  );

  assign done_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      rsp_valid <= 1'b1;
      rsp       <= done;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  `BFLD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
  `BFLD_ASSERT_SAME(a_pop_excl, rsp_valid && rsp.read_valid,
                    !rsp.write_accepted && (rsp.line_status == bfld_pkg::ST_NONE))
  `BFLD_ASSERT_SAME(a_len_only_complete,
                    rsp_valid && (rsp.line_status != bfld_pkg::ST_COMPLETE),
                    rsp.line_length == '0)

endmodule
